// ----- src/mipds_pkg.sv -----
// ----------------------------------------------------------------------------
// mipds_pkg
// Shared constants, register indexes and types of the mip level 2x2 box
// downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package mipds_pkg;

  // Pixel layout.
  localparam int NUM_CH    = 4;
  localparam int CHAN_BITS = 16;
  localparam int PSUM_BITS = CHAN_BITS + 1;  // sum of two channel values
  localparam int TOT_BITS  = CHAN_BITS + 2;  // sum of four channel values

  // Geometry limits.
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int HGT_BITS      = 13;   // holds HEIGHT_LIMIT itself
  localparam int ROW_BITS      = 12;   // row position, below HEIGHT_LIMIT

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;
  localparam int NCH_BITS      = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;

  typedef logic [NUM_CH-1:0][CHAN_BITS-1:0] pix_t;
  typedef logic [NUM_CH-1:0][PSUM_BITS-1:0] psum_t;

  // Per-beat control handed from the front end to the averaging stage.
  typedef struct packed {
    logic                emit;   // this beat completes a 2x2 block
    logic                h_one; // single-row level: pair the row with itself
    logic                last;  // last output pixel of the level
    logic [NCH_BITS-1:0] nch;   // channels in use, already clamped
  } ctl_t;

endpackage

`default_nettype wire

// ----- src/mipds_line_mem.sv -----
// ----------------------------------------------------------------------------
// mipds_line_mem
// Line store of horizontal pair sums, one write and one read port, with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mipds_line_mem #(
  parameter int DEPTH = mipds_pkg::DEF_MAX_WIDTH / 2,
  parameter int AW    = 11
) (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire  [AW-1:0]        waddr_i,
  input  mipds_pkg::psum_t     wdata_i,
  input  wire                  re_i,
  input  wire  [AW-1:0]        raddr_i,
  output mipds_pkg::psum_t     rdata_o
);

  mipds_pkg::psum_t mem [DEPTH];
  mipds_pkg::psum_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/mipds_ctrl.sv -----
// ----------------------------------------------------------------------------
// mipds_ctrl
// Configuration registers, raster position tracking, horizontal pairing and
// line store access of the downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

module mipds_ctrl #(
  parameter int MAX_WIDTH = mipds_pkg::DEF_MAX_WIDTH,
  parameter int AW        = 11
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [mipds_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire  [mipds_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire                                  accept_i,
  input  mipds_pkg::pix_t                      pix_i,
  output logic                                 mem_we_o,
  output logic                                 mem_re_o,
  output logic [AW-1:0]                        mem_addr_o,
  output mipds_pkg::psum_t                     hsum_o,
  output mipds_pkg::ctl_t                      ctl_o
);

  localparam int CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > mipds_pkg::CFG_DATA_BITS) ? WW : mipds_pkg::CFG_DATA_BITS;
  localparam int HW   = mipds_pkg::HGT_BITS;
  localparam int RB   = mipds_pkg::ROW_BITS;
  localparam int NB   = mipds_pkg::NCH_BITS;

  logic [mipds_pkg::CFG_DATA_BITS-1:0] width_q, width_d;
  logic [mipds_pkg::CFG_DATA_BITS-1:0] height_q, height_d;
  logic [NB-1:0]                       nch_q, nch_d;
  logic [CW-1:0]                       col_q, col_d;
  logic [RB-1:0]                       row_q, row_d;
  mipds_pkg::pix_t                     left_q;

  logic [CMPW-1:0] w_ext;
  logic [WW-1:0]   w_eff;
  logic [WW-1:0]   ow_m1;
  logic [HW-1:0]   h_eff;
  logic [HW-1:0]   oh_m1;
  logic [HW-1:0]   orow;
  logic [NB-1:0]   nch_eff;
  logic            w_one;
  logic            h_one;
  logic            have_pair;
  logic            emit;
  logic [AW-1:0]   idx;
  logic [WW-1:0]   col_inc;
  logic [HW-1:0]   row_inc;

  // Clamp the registers to the supported geometry.
  always_comb begin
    w_ext = CMPW'(width_q);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_ext);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (height_q > HW'(mipds_pkg::HEIGHT_LIMIT)) begin
      h_eff = HW'(mipds_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = height_q;
    end
    if (nch_q == '0) begin
      nch_eff = NB'(1);
    end else if (nch_q > NB'(mipds_pkg::NUM_CH)) begin
      nch_eff = NB'(mipds_pkg::NUM_CH);
    end else begin
      nch_eff = nch_q;
    end
    w_one = (w_eff == WW'(1));
    h_one = (h_eff == HW'(1));
    ow_m1 = w_one ? '0 : (w_eff >> 1) - WW'(1);
    oh_m1 = h_one ? '0 : (h_eff >> 1) - HW'(1);
  end

  // Horizontal pairing and line store addressing for the current beat.
  always_comb begin
    have_pair = w_one | col_q[0];
    idx       = w_one ? '0 : AW'(col_q >> 1);
    emit      = have_pair & (h_one | row_q[0]);
    orow      = h_one ? '0 : HW'(row_q >> 1);
    for (int k = 0; k < mipds_pkg::NUM_CH; k++) begin
      hsum_o[k] = w_one ? {pix_i[k], 1'b0}
                        : mipds_pkg::PSUM_BITS'(left_q[k]) + mipds_pkg::PSUM_BITS'(pix_i[k]);
    end
    mem_addr_o = idx;
    mem_we_o   = accept_i & have_pair & ~h_one & ~row_q[0];
    mem_re_o   = accept_i & emit & ~h_one;
    ctl_o.emit  = emit;
    ctl_o.h_one = h_one;
    ctl_o.last  = (WW'(idx) == ow_m1) && (orow == oh_m1);
    ctl_o.nch   = nch_eff;
  end

  // Next register values: geometry writes restart the level.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    nch_d    = nch_q;
    col_d    = col_q;
    row_d    = row_q;
    col_inc  = WW'(col_q) + WW'(1);
    row_inc  = HW'(row_q) + HW'(1);
    if (cfg_we_i) begin
      case (cfg_index_i)
        mipds_pkg::REG_SOURCE_WIDTH: begin
          width_d = cfg_data_i;
          col_d   = '0;
          row_d   = '0;
        end
        mipds_pkg::REG_SOURCE_HEIGHT: begin
          height_d = cfg_data_i;
          col_d    = '0;
          row_d    = '0;
        end
        mipds_pkg::REG_CHANNEL_COUNT: begin
          nch_d = cfg_data_i[NB-1:0];
        end
        default: begin
        end
      endcase
    end else if (accept_i) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc >= h_eff) ? '0 : RB'(row_inc);
      end else begin
        col_d = CW'(col_inc);
      end
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mipds_pkg::CFG_DATA_BITS'(1);
      height_q <= mipds_pkg::CFG_DATA_BITS'(1);
      nch_q    <= NB'(mipds_pkg::NUM_CH);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      nch_q    <= nch_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // Pixel of the even column, held for its right neighbor.
  always_ff @(posedge clk_i) begin
    if (accept_i && !have_pair) begin
      left_q <= pix_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/mipds_avg.sv -----
// ----------------------------------------------------------------------------
// mipds_avg
// Vertical sum, rounding and output register of the downsampler, with the
// stall logic of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module mipds_avg (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     accept_i,
  input  mipds_pkg::ctl_t         ctl_i,
  input  mipds_pkg::psum_t        hsum_i,
  input  mipds_pkg::psum_t        line_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output mipds_pkg::pix_t         out_data_o,
  output logic                    out_last_o
);

  localparam int TB = mipds_pkg::TOT_BITS;
  localparam int NB = mipds_pkg::NCH_BITS;

  logic             s1_valid_q, s1_valid_d;
  mipds_pkg::ctl_t  s1_ctl_q;
  mipds_pkg::psum_t s1_hsum_q;
  logic             out_valid_q, out_valid_d;
  mipds_pkg::pix_t  out_data_q;
  mipds_pkg::pix_t  avg;
  logic             out_last_q;
  logic             advance;
  logic [TB-1:0]    total;
  logic [TB-1:0]    rounded;

  // The stage moves on when the output register is free or being emptied.
  assign advance = ~out_valid_q | out_ready_i;
  assign ready_o = ~s1_valid_q | advance;

  always_comb begin
    s1_valid_d  = accept_i ? ctl_i.emit : (advance ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  // Block total per channel and round half up.
  always_comb begin
    total   = '0;
    rounded = '0;
    for (int k = 0; k < mipds_pkg::NUM_CH; k++) begin
      if (s1_ctl_q.h_one) begin
        total = {s1_hsum_q[k], 1'b0};
      end else begin
        total = TB'(line_i[k]) + TB'(s1_hsum_q[k]);
      end
      rounded = total + TB'(2);
      avg[k]  = (NB'(k) < s1_ctl_q.nch) ? rounded[TB-1:2] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stage payload, loaded with each accepted beat.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_ctl_q  <= ctl_i;
      s1_hsum_q <= hsum_i;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_data_q <= avg;
      out_last_q <= s1_ctl_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ----- src/mip_level_box_downsampler.sv -----
// ----------------------------------------------------------------------------
// mip_level_box_downsampler
// 2x2 box filter that reduces one mip level to the next.
// ----------------------------------------------------------------------------
// Source pixels enter on the s_axis channel in raster order, one beat per
// pixel, four 16-bit channels each. For every 2x2 block one pixel of the next
// level leaves on the m_axis channel: per channel the rounded mean of the
// four pixels. tlast marks the last pixel of the output level. Odd trailing
// rows and columns produce nothing; a dimension of one pairs with itself.
// Geometry and channel count are set through the write port while idle;
// writing width or height restarts the level at its first pixel.
// Throughput is one source pixel per cycle while the receiver keeps up: each pixel does at most one
// access to the pair-sum line store, which has one write and one read port.
// A result is formed in two steps: the line store read, registered alongside the stage register
// that holds the completing beat, and then the summing into the output register.
// When the receiver stalls, the output register holds and the stage before
// it fills; s_axis_tready then drops until the output beat is taken.
// Reset clears the positions and restores width 1, height 1 and four
// channels; the line store needs no clearing, since every entry is written
// on an even row before the odd row reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_level_box_downsampler #(
  parameter int MAX_WIDTH = mipds_pkg::DEF_MAX_WIDTH
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // Configuration write port.
  input  wire                                  cfg_we_i,
  input  wire  [mipds_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire  [mipds_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // Source pixels.
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [63:0]                          s_axis_tdata,  // chan_0..chan_3
  // Reduced pixels.
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [63:0]                          m_axis_tdata,  // avg_0..avg_3
  output logic                                 m_axis_tlast   // level_done
);

  localparam int DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             accept;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_addr;
  mipds_pkg::psum_t hsum;
  mipds_pkg::psum_t line_rd;
  mipds_pkg::ctl_t  ctl;
  mipds_pkg::pix_t  pix_in;
  mipds_pkg::pix_t  pix_out;

  assign accept = s_axis_tvalid & s_axis_tready;
  assign pix_in = s_axis_tdata;

  // Position tracking, pairing and line store control.
  mipds_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .pix_i       (pix_in),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .hsum_o      (hsum),
    .ctl_o       (ctl)
  );

  // Pair sums of the even row.
  mipds_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (hsum),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (line_rd)
  );

  // Block sum, rounding and output register.
  mipds_avg u_avg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .ctl_i       (ctl),
    .hsum_i      (hsum),
    .line_i      (line_rd),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (pix_out),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = pix_out;

endmodule

`default_nettype wire

// ----- tb/sv/tb_mip_level_box_downsampler.sv -----
// ----------------------------------------------------------------------------
// tb_mip_level_box_downsampler
// Self-checking testbench of the mip level 2x2 box downsampler.
// ----------------------------------------------------------------------------
// Source pixels are streamed in bursts with random gaps while the output side
// stalls on a changing pattern of its own. Every accepted source beat is run
// through a bit-exact predictor of the filter (position counters, held left
// pixel and the pair-sum line store), which queues the reduced pixel it
// expects. Every output beat is compared field by field with the oldest
// queued pixel. A directed part covers the channel extremes, rounding, odd
// trailing rows and columns, single-row and single-column levels and the
// saturation of out-of-range settings; partial levels at the largest width
// and height follow, and random geometries make up the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mip_level_box_downsampler;

  localparam int          RANDOM_ITEMS     = 450;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          TAIL_CYCLES      = 20;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          LINE_DEPTH       = mipds_pkg::DEF_MAX_WIDTH / 2;
  localparam longint      WATCHDOG_TIME    = 64'd10_000_000;
  localparam logic [mipds_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  // One reduced pixel as it leaves the block.
  typedef struct packed {
    mipds_pkg::pix_t avg;
    logic            done;
  } reduced_pixel_t;

  // Predictor of the filter and store of the reduced pixels still due.
  class box_filter_scoreboard;
    int unsigned          src_width;
    int unsigned          src_height;
    int unsigned          chan_count;
    int unsigned          col;
    int unsigned          row;
    mipds_pkg::pix_t      left_pix;
    mipds_pkg::psum_t     pair_line [LINE_DEPTH];
    reduced_pixel_t       expected_q [$];
    int                   mismatches;
    int                   beats_seen;

    function new();
      src_width  = 1;
      src_height = 1;
      chan_count = 4;
      col        = 0;
      row        = 0;
      left_pix   = '0;
      mismatches = 0;
      beats_seen = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Register write; a geometry write restarts the level.
    function void apply_register(logic [mipds_pkg::CFG_IDX_BITS-1:0] idx,
                                 logic [mipds_pkg::CFG_DATA_BITS-1:0] val);
      case (idx)
        mipds_pkg::REG_SOURCE_WIDTH: begin
          src_width = 32'(val);
          col = 0;
          row = 0;
        end
        mipds_pkg::REG_SOURCE_HEIGHT: begin
          src_height = 32'(val);
          col = 0;
          row = 0;
        end
        mipds_pkg::REG_CHANNEL_COUNT: begin
          chan_count = 32'(val[mipds_pkg::NCH_BITS-1:0]);
        end
        default: begin
        end
      endcase
    endfunction

    // One accepted source pixel; queues a reduced pixel when a block closes.
    function void note_pixel(mipds_pkg::pix_t px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      nch;
      int unsigned      ow;
      int unsigned      oh;
      int unsigned      idx;
      int unsigned      orow;
      int unsigned      total;
      mipds_pkg::psum_t hsum;
      bit               have_pair;
      reduced_pixel_t   res;
      w   = clamp_dim(src_width, mipds_pkg::DEF_MAX_WIDTH);
      h   = clamp_dim(src_height, mipds_pkg::HEIGHT_LIMIT);
      nch = clamp_dim(chan_count, mipds_pkg::NUM_CH);
      ow  = ((w >> 1) != 0) ? (w >> 1) : 1;
      oh  = ((h >> 1) != 0) ? (h >> 1) : 1;
      have_pair = 1'b0;
      idx  = 0;
      hsum = '0;

      // Horizontal pair: a single column pairs with itself.
      if (w == 1) begin
        for (int k = 0; k < mipds_pkg::NUM_CH; k++) hsum[k] = {px[k], 1'b0};
        have_pair = 1'b1;
      end else if (col[0]) begin
        for (int k = 0; k < mipds_pkg::NUM_CH; k++)
          hsum[k] = mipds_pkg::PSUM_BITS'(left_pix[k]) + mipds_pkg::PSUM_BITS'(px[k]);
        have_pair = 1'b1;
        idx = col >> 1;
      end else begin
        left_pix = px;
      end

      // Vertical pair: even rows fill the line store, odd rows close blocks.
      if (have_pair) begin
        if (h == 1 || row[0]) begin
          res = '0;
          for (int k = 0; k < mipds_pkg::NUM_CH; k++) begin
            if (h == 1) total = 32'(hsum[k]) * 2;
            else total = 32'(pair_line[idx][k]) + 32'(hsum[k]);
            if (k < nch) res.avg[k] = mipds_pkg::CHAN_BITS'((total + 2) >> 2);
          end
          orow = (h == 1) ? 0 : (row >> 1);
          res.done = (idx == ow - 1) && (orow == oh - 1);
          expected_q.insert(expected_q.size(), res);
        end else begin
          pair_line[idx] = hsum;
        end
      end

      // Raster position; the level wraps to its first pixel.
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    task log_mismatch(string what);
      $display("mismatch at output beat %0d: %s", beats_seen, what);
      mismatches++;
    endtask

    // One accepted output beat against the oldest queued pixel.
    task check_beat(mipds_pkg::pix_t avg, logic done);
      reduced_pixel_t want;
      beats_seen++;
      if (expected_q.size() == 0) begin
        log_mismatch("output beat with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      for (int k = 0; k < mipds_pkg::NUM_CH; k++) begin
        if (avg[k] !== want.avg[k])
          log_mismatch($sformatf("avg_%0d is %h, predicted %h", k, avg[k], want.avg[k]));
      end
      if (done !== want.done)
        log_mismatch($sformatf("level_done is %b, predicted %b", done, want.done));
    endtask
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [mipds_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [mipds_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                                s_valid = 1'b0;
  mipds_pkg::pix_t                     s_data = '0;
  logic                                m_ready = 1'b0;
  logic                                long_hold_req = 1'b0;
  wire                                 s_axis_tready;
  wire                                 m_axis_tvalid;
  wire  [63:0]                         m_axis_tdata;
  wire                                 m_axis_tlast;

  box_filter_scoreboard     sb = new();
  int                       burst_left = 0;

  mip_level_box_downsampler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),        // chan_0..chan_3
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),  // avg_0..avg_3
    .m_axis_tlast  (m_axis_tlast)   // level_done
  );

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output monitor: every accepted beat is checked.
  always @(posedge clk_i) begin
    if (rst_n && m_axis_tvalid && m_ready) sb.check_beat(m_axis_tdata, m_axis_tlast);
  end

  // Receiver: stall pattern in spans of changing mode, plus a long hold-off
  // on each request.
  initial begin : rx_stall
    int mode;
    int span;
    mode = 0;
    span = 0;
    wait (rst_n);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        m_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_req <= 1'b0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 200);
      end
      span--;
      case (mode)
        0:       m_ready <= 1'b1;
        1:       m_ready <= 1'($urandom_range(0, 1));
        2:       m_ready <= ($urandom_range(0, 3) != 0);
        default: m_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Watchdog.
  initial begin
    #WATCHDOG_TIME;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic mipds_pkg::pix_t make_pixel(logic [15:0] c0, logic [15:0] c1,
                                                 logic [15:0] c2, logic [15:0] c3);
    mipds_pkg::pix_t px;
    px[0] = c0;
    px[1] = c1;
    px[2] = c2;
    px[3] = c3;
    return px;
  endfunction

  // Random pixel, with the channel extremes made frequent.
  function automatic mipds_pkg::pix_t random_pixel();
    mipds_pkg::pix_t px;
    int              pick;
    for (int k = 0; k < mipds_pkg::NUM_CH; k++) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) px[k] = 16'h0000;
      else if (pick == 1) px[k] = 16'hFFFF;
      else px[k] = 16'($urandom_range(0, 65535));
    end
    return px;
  endfunction

  // Offers one source beat inside a burst; a new burst may start after a gap.
  task automatic send_pixel(input mipds_pkg::pix_t px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pixel(px);
  endtask

  // Stops the stream and waits until every predicted pixel has come out.
  task automatic await_drain();
    s_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes width, height and channel count on consecutive cycles, and the
  // unused index last when asked.
  task automatic configure(input logic [mipds_pkg::CFG_DATA_BITS-1:0] w_val,
                           input logic [mipds_pkg::CFG_DATA_BITS-1:0] h_val,
                           input logic [mipds_pkg::CFG_DATA_BITS-1:0] n_val,
                           input bit touch_spare);
    cfg_we    <= 1'b1;
    cfg_index <= mipds_pkg::REG_SOURCE_WIDTH;
    cfg_data  <= w_val;
    @(posedge clk_i);
    sb.apply_register(mipds_pkg::REG_SOURCE_WIDTH, w_val);
    cfg_index <= mipds_pkg::REG_SOURCE_HEIGHT;
    cfg_data  <= h_val;
    @(posedge clk_i);
    sb.apply_register(mipds_pkg::REG_SOURCE_HEIGHT, h_val);
    cfg_index <= mipds_pkg::REG_CHANNEL_COUNT;
    cfg_data  <= n_val;
    @(posedge clk_i);
    sb.apply_register(mipds_pkg::REG_CHANNEL_COUNT, n_val);
    if (touch_spare) begin
      cfg_index <= REG_SPARE;
      cfg_data  <= mipds_pkg::CFG_DATA_BITS'($urandom_range(0, 8191));
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [mipds_pkg::CFG_DATA_BITS-1:0] oversize_dim();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) return '0;
    if (pick == 1) return 13'd8191;
    return mipds_pkg::CFG_DATA_BITS'($urandom_range(4097, 8190));
  endfunction

  // Stimulus.
  initial begin : stimulus
    int                                  random_sent;
    int                                  group;
    int                                  sel;
    int unsigned                         w_eff;
    int unsigned                         h_eff;
    int unsigned                         level_items;
    int unsigned                         n_items;
    logic [mipds_pkg::CFG_DATA_BITS-1:0] w_raw;
    logic [mipds_pkg::CFG_DATA_BITS-1:0] h_raw;
    logic [mipds_pkg::CFG_DATA_BITS-1:0] n_raw;
    random_sent = 0;
    group = 0;

    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: each pixel is its own block and ends the level.
    send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(make_pixel(16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE));

    // Full-scale sum and rounding of quarters and halves.
    await_drain();
    configure(13'd2, 13'd2, 13'd4, 1'b1);
    send_pixel(make_pixel(16'hFFFF, 16'h0001, 16'h0002, 16'h0000));
    send_pixel(make_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(make_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0001));
    send_pixel(make_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0001));

    // Odd trailing row and column, one channel in use.
    await_drain();
    configure(13'd3, 13'd3, 13'd1, 1'b0);
    repeat (9) send_pixel(random_pixel());

    // Single column paired with itself.
    await_drain();
    configure(13'd1, 13'd2, 13'd2, 1'b0);
    repeat (2) send_pixel(random_pixel());

    // Single row paired with itself.
    await_drain();
    configure(13'd4, 13'd1, 13'd3, 1'b0);
    repeat (4) send_pixel(random_pixel());

    // Zero settings saturate to one.
    await_drain();
    configure(13'd0, 13'd0, 13'd0, 1'b1);
    repeat (2) send_pixel(random_pixel());

    // Start of the tallest level, width zero saturating to one column.
    await_drain();
    configure(13'd0, 13'd4096, 13'd7, 1'b0);
    repeat (64) send_pixel(random_pixel());

    // Oversize width saturating, single row, under one long receiver
    // hold-off so that the block fills and stalls its input.
    await_drain();
    configure(13'd8191, 13'd0, 13'd4, 1'b0);
    long_hold_req <= 1'b1;
    repeat (64) send_pixel(random_pixel());

    // Random geometries: mostly whole levels, some broken off mid-level.
    while (random_sent < RANDOM_ITEMS) begin
      sel   = $urandom_range(0, 9);
      w_raw = mipds_pkg::CFG_DATA_BITS'($urandom_range(1, 9));
      h_raw = mipds_pkg::CFG_DATA_BITS'($urandom_range(1, 9));
      if (sel == 0) w_raw = oversize_dim();
      else if (sel == 1) h_raw = oversize_dim();
      n_raw = mipds_pkg::CFG_DATA_BITS'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0)
        n_raw[mipds_pkg::CFG_DATA_BITS-1:mipds_pkg::NCH_BITS] = 10'($urandom);
      w_eff = (w_raw == 0) ? 1 : ((w_raw > mipds_pkg::DEF_MAX_WIDTH) ?
                                  mipds_pkg::DEF_MAX_WIDTH : 32'(w_raw));
      h_eff = (h_raw == 0) ? 1 : ((h_raw > mipds_pkg::HEIGHT_LIMIT) ?
                                  mipds_pkg::HEIGHT_LIMIT : 32'(h_raw));
      level_items = w_eff * h_eff;
      if (level_items > 64) n_items = $urandom_range(1, 64);
      else if ($urandom_range(0, 5) == 0) n_items = $urandom_range(1, level_items);
      else n_items = level_items * $urandom_range(1, 2);

      await_drain();
      configure(w_raw, h_raw, n_raw, ($urandom_range(0, 7) == 0));
      if (group == 3) long_hold_req <= 1'b1;
      repeat (n_items) begin
        send_pixel(random_pixel());
        random_sent++;
      end
      group++;
    end

    // Drain and let the pipeline run empty.
    await_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
